>>> hw/rtl/wbss_pkg.sv
// Shared types and constants of the wildcard byte signature scanner.
`timescale 1ns / 1ps

package wbss_pkg;

   localparam int DEF_MAX_PATTERN = 16;
   localparam int CSR_INDEX_W     = 8;
   localparam int CSR_DATA_W      = 64;
   localparam int ADDR_W          = 32;
   localparam int CFG_LEN_W       = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WILDCARD     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH       = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_BASE   = 8'd4;

   typedef struct packed {
      logic [127:0]          pattern;
      logic [15:0]           wildcard_mask;
      logic [CFG_LEN_W-1:0]  pattern_length;
      logic [ADDR_W-1:0]     range_base;
   } cfg_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } result_type;

endpackage

>>> hw/rtl/wbss_match.sv
// Masked compare of the byte window against the signature.
`timescale 1ns / 1ps

module wbss_match #(
   parameter int MAX_PATTERN = wbss_pkg::DEF_MAX_PATTERN,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
   parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic [MAX_PATTERN-1:0][7:0] window,
   input  wbss_pkg::cfg_type           cfg,
   input  logic [LEN_W-1:0]            eff_len,
   output logic                        hit
);

   // Signature byte i lines up with window entry eff_len-1-i, entry 0 the newest byte.
   always_comb begin
      logic [IDX_W-1:0] sel;
      hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         sel = IDX_W'(eff_len - LEN_W'(1) - LEN_W'(i));
         if ((LEN_W'(i) < eff_len) && !cfg.wildcard_mask[i] &&
             (window[sel] != cfg.pattern[8*i +: 8])) begin
            hit = 1'b0;
         end
      end
   end

endmodule

>>> hw/rtl/wbss_core.sv
// Scan state: byte window, byte count, report flag and result generation.
`timescale 1ns / 1ps

module wbss_core #(
   parameter int MAX_PATTERN = wbss_pkg::DEF_MAX_PATTERN
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_beat,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  wbss_pkg::cfg_type    cfg,
   output logic                 res_push,
   output wbss_pkg::result_type res_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int AW    = wbss_pkg::ADDR_W;

   logic [MAX_PATTERN-1:0][7:0] window_ff, window_in;
   logic [AW-1:0]               seen_ff, seen_in;
   logic                        reported_ff, reported_in;
   logic [LEN_W-1:0]            eff_len;
   logic                        hit;

   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg.pattern_length > wbss_pkg::CFG_LEN_W'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = LEN_W'(cfg.pattern_length);
      end
   end

   always_comb begin
      window_in[0] = in_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
      seen_in = (seen_ff == '1) ? seen_ff : seen_ff + AW'(1);
   end

   wbss_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .window  (window_in),
      .cfg     (cfg),
      .eff_len (eff_len),
      .hit     (hit)
   );

   logic match_now;
   assign match_now = hit && (seen_in >= AW'(eff_len));

   always_comb begin
      reported_in            = reported_ff;
      res_push               = 1'b0;
      res_data.found         = 1'b0;
      res_data.match_address = '0;
      if (in_beat && !reported_ff) begin
         if (match_now) begin
            res_push               = 1'b1;
            res_data.found         = 1'b1;
            res_data.match_address = cfg.range_base + seen_in - AW'(eff_len);
            reported_in            = !in_last;
         end else if (in_last) begin
            res_push = 1'b1;
         end
      end else if (in_beat && in_last) begin
         reported_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (in_beat) begin
         reported_ff <= reported_in;
         if (in_last) begin
            seen_ff <= '0;
         end else if (!reported_ff) begin
            seen_ff <= seen_in;
         end
      end
   end

   // The window is only read over bytes taken since the last rearm.
   always_ff @(posedge clock) begin
      if (in_beat && !reported_ff) begin
         window_ff <= window_in;
      end
   end

endmodule

>>> hw/rtl/wbss_rsp_queue.sv
// Two-entry result queue that decouples the scan from the result channel.
`timescale 1ns / 1ps

module wbss_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wbss_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output wbss_pkg::result_type out_data
);

   wbss_pkg::result_type entry_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/wildcard_byte_signature_scan_top.sv
// A result is pushed into the result queue on its byte beat; rsp offers the queue head.
// Throughput: one byte per cycle while the result queue is not full; the scan, a window
// shift plus a masked compare of all signature bytes, finishes within the cycle of the
// beat, and a two-entry result queue lets bytes keep flowing while a result waits.
// Reset: synchronous, active high; clears the scan state, the queue and the registers
// (pattern_length to 1, others to 0). No clearing pass; bytes are accepted right after.
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_top #(
   parameter int MAX_PATTERN = wbss_pkg::DEF_MAX_PATTERN
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: data_byte [7:0]
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: match_address [31:0]
   output logic [wbss_pkg::ADDR_W-1:0]         rsp_tdata,
   // rsp_tuser: found [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wbss_pkg::CSR_DATA_W-1:0]     csr_data
);

   wbss_pkg::cfg_type    cfg_ff;
   wbss_pkg::result_type res_data, out_data;
   logic                 res_push, queue_full, in_beat;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign in_beat    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern        <= '0;
         cfg_ff.wildcard_mask  <= '0;
         cfg_ff.pattern_length <= wbss_pkg::CFG_LEN_W'(1);
         cfg_ff.range_base     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wbss_pkg::CSR_PATTERN_LOW:  cfg_ff.pattern[63:0]   <= csr_data;
            wbss_pkg::CSR_PATTERN_HIGH: cfg_ff.pattern[127:64] <= csr_data;
            wbss_pkg::CSR_WILDCARD:     cfg_ff.wildcard_mask   <= csr_data[15:0];
            wbss_pkg::CSR_LENGTH: begin
               cfg_ff.pattern_length <= csr_data[wbss_pkg::CFG_LEN_W-1:0];
            end
            wbss_pkg::CSR_RANGE_BASE: begin
               cfg_ff.range_base <= csr_data[wbss_pkg::ADDR_W-1:0];
            end
            default: ;
         endcase
      end
   end

   wbss_core #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (in_beat),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .cfg      (cfg_ff),
      .res_push (res_push),
      .res_data (res_data)
   );

   wbss_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data.match_address;
   assign rsp_tuser = out_data.found;

endmodule

>>> dv/wildcard_byte_signature_scan_top_tb.sv
// Testbench for the wildcard byte signature scanner: directed and random byte ranges.
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_top_tb;

   localparam int SCAN_TARGET  = 1200;
   localparam int PHASE_BYTES  = 100;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_LIMIT  = 4000;
   localparam int IDLE_PERCENT = 12;
   localparam logic [wbss_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_FIRST =
      wbss_pkg::CSR_RANGE_BASE + 8'd1;
   localparam logic [wbss_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LAST  = '1;

   typedef enum {RANGE_PLANTED, RANGE_NEAR_MISS, RANGE_DENSE, RANGE_NOISE} range_kind_type;

   class scan_scoreboard;
      bit [63:0]            sig_low;
      bit [63:0]            sig_high;
      bit [15:0]            wild;
      bit [4:0]             sig_len;
      bit [31:0]            base_addr;
      bit [7:0]             window_bytes [16];
      bit [31:0]            seen;
      bit                   reported;
      int                   scanned;
      int                   errors;
      wbss_pkg::result_type awaited_results [$];

      function new();
         sig_len = 5'd1;
      endfunction

      function void write_reg(logic [wbss_pkg::CSR_INDEX_W-1:0] index,
                              logic [wbss_pkg::CSR_DATA_W-1:0] value);
         case (index)
            wbss_pkg::CSR_PATTERN_LOW:  sig_low = value;
            wbss_pkg::CSR_PATTERN_HIGH: sig_high = value;
            wbss_pkg::CSR_WILDCARD:     wild = value[15:0];
            wbss_pkg::CSR_LENGTH:       sig_len = value[wbss_pkg::CFG_LEN_W-1:0];
            wbss_pkg::CSR_RANGE_BASE:   base_addr = value[wbss_pkg::ADDR_W-1:0];
            default: ;
         endcase
      endfunction

      function int effective_length();
         if (sig_len == 0) return 1;
         if (sig_len > wbss_pkg::DEF_MAX_PATTERN) return wbss_pkg::DEF_MAX_PATTERN;
         return sig_len;
      endfunction

      function void rearm();
         seen = '0;
         reported = 1'b0;
      endfunction

      function void note_byte(logic [7:0] data_byte, logic last_byte);
         int                   n;
         bit                   hit;
         bit [127:0]           sig;
         wbss_pkg::result_type outcome;
         n = effective_length();
         sig = {sig_high, sig_low};
         scanned++;
         if (reported) begin
            if (last_byte) rearm();
            return;
         end
         for (int k = 15; k > 0; k--) window_bytes[k] = window_bytes[k - 1];
         window_bytes[0] = data_byte;
         if (seen != '1) seen++;
         hit = (seen >= n);
         for (int i = 0; i < n; i++) begin
            if (!wild[i] && window_bytes[n - 1 - i] != sig[8 * i +: 8]) hit = 0;
         end
         if (hit) begin
            outcome.found = 1'b1;
            outcome.match_address = base_addr + (seen - n);
            awaited_results.push_back(outcome);
            if (last_byte) rearm();
            else reported = 1;
         end else if (last_byte) begin
            outcome = '0;
            awaited_results.push_back(outcome);
            rearm();
         end
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task check_result(logic found, logic [wbss_pkg::ADDR_W-1:0] addr);
         wbss_pkg::result_type want;
         if (awaited_results.size() == 0) begin
            report($sformatf("unexpected result found=%0b address=%h", found, addr));
            return;
         end
         want = awaited_results.pop_front();
         if (found !== want.found)
            report($sformatf("found %0b, wanted %0b", found, want.found));
         if (addr !== want.match_address)
            report($sformatf("match address %h, wanted %h", addr, want.match_address));
      endtask

      task check_drained();
         if (awaited_results.size() != 0)
            report($sformatf("%0d expected results never arrived", awaited_results.size()));
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic [7:0]                        req_tdata;
   logic                              req_tlast;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [wbss_pkg::ADDR_W-1:0]       rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [wbss_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [wbss_pkg::CSR_DATA_W-1:0]   csr_data;
   logic                              quiet = 1'b0;
   int                                stalled_cycles = 0;
   scan_scoreboard                    sb = new();

   wildcard_byte_signature_scan_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tlast  <= last_byte;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(data_byte, last_byte);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [wbss_pkg::CSR_INDEX_W-1:0] index,
                            input logic [wbss_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
      @(negedge clock);
   endtask

   // Stops driving bytes and waits until every awaited result has arrived, plus a drain margin.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic pick_scan_setup();
      logic [wbss_pkg::CSR_DATA_W-1:0] value;
      int                              roll;
      roll = $urandom_range(99);
      value = {$urandom, $urandom};
      if (roll < 60) value[4:0] = 5'($urandom_range(1, 6));
      else if (roll < 75) value[4:0] = 5'($urandom_range(7, 15));
      else if (roll < 85) value[4:0] = 5'(wbss_pkg::DEF_MAX_PATTERN);
      else if (roll < 92) value[4:0] = 5'd0;
      else value[4:0] = 5'($urandom_range(17, 31));
      csr_write(wbss_pkg::CSR_LENGTH, value);
      csr_write(wbss_pkg::CSR_PATTERN_LOW, {$urandom, $urandom});
      csr_write(wbss_pkg::CSR_PATTERN_HIGH, {$urandom, $urandom});
      value = {$urandom, $urandom};
      roll = $urandom_range(9);
      if (roll == 0) value[15:0] = '0;
      else if (roll == 1) value[15:0] = '1;
      else value[15:0] = 16'($urandom & $urandom & $urandom);
      csr_write(wbss_pkg::CSR_WILDCARD, value);
      value = {$urandom, $urandom};
      roll = $urandom_range(3);
      if (roll == 0) value[31:0] = '0;
      else if (roll == 1) value[31:0] = {28'hFFFFFFF, 4'($urandom)};
      csr_write(wbss_pkg::CSR_RANGE_BASE, value);
      csr_valid <= 1'b0;
   endtask

   task automatic send_range(input range_kind_type kind);
      logic [7:0]   range_bytes [];
      logic [127:0] sig;
      int           n, count, spot, k, j;
      n = sb.effective_length();
      sig = {sb.sig_high, sb.sig_low};
      if (kind == RANGE_PLANTED || kind == RANGE_NEAR_MISS) count = n + $urandom_range(0, 20);
      else if ($urandom_range(9) == 0) count = $urandom_range(25, 60);
      else count = $urandom_range(1, 24);
      range_bytes = new[count];
      for (j = 0; j < count; j++) begin
         if (kind != RANGE_NOISE && $urandom_range(1) == 1)
            range_bytes[j] = sig[8 * $urandom_range(n - 1) +: 8];
         else
            range_bytes[j] = 8'($urandom);
      end
      if (kind == RANGE_PLANTED || kind == RANGE_NEAR_MISS) begin
         spot = $urandom_range(count - n);
         for (j = 0; j < n; j++)
            range_bytes[spot + j] = sb.wild[j] ? 8'($urandom) : sig[8 * j +: 8];
         if (kind == RANGE_NEAR_MISS) begin
            k = $urandom_range(n - 1);
            if (!sb.wild[k]) range_bytes[spot + k] = ~range_bytes[spot + k];
         end
      end
      for (j = 0; j < count; j++) send_byte(range_bytes[j], j == count - 1);
   endtask

   initial begin
      int             phase, start, mark, roll;
      range_kind_type kind;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Signature DE ?? BE EF; upper mask bits and unused indexes must be ignored.
      csr_write(wbss_pkg::CSR_PATTERN_LOW, 64'h0000_0000_EFBE_00DE);
      csr_write(wbss_pkg::CSR_PATTERN_HIGH, '1);
      csr_write(wbss_pkg::CSR_WILDCARD, 64'hFFFF_FFFF_FFFF_0002);
      csr_write(wbss_pkg::CSR_LENGTH, 64'd4);
      csr_write(wbss_pkg::CSR_RANGE_BASE, 64'd0);
      csr_write(CSR_UNUSED_FIRST, '1);
      csr_write(CSR_UNUSED_LAST, '1);
      csr_valid <= 1'b0;

      // Overlapping candidate, with a base change in the middle of the range.
      send_byte(8'hDE, 1'b0);
      send_byte(8'hDE, 1'b0);
      wait_idle();
      csr_write(wbss_pkg::CSR_RANGE_BASE, 64'hFFFF_FFFE);
      csr_valid <= 1'b0;
      send_byte(8'h11, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b1);
      send_byte(8'hDE, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hEF, 1'b1);
      send_byte(8'hDE, 1'b1);

      // Full-length signature with an over-range length code, wildcards at both ends.
      wait_idle();
      csr_write(wbss_pkg::CSR_LENGTH, 64'd31);
      csr_write(wbss_pkg::CSR_PATTERN_LOW, '0);
      csr_write(wbss_pkg::CSR_PATTERN_HIGH, '1);
      csr_write(wbss_pkg::CSR_WILDCARD, 64'h8001);
      csr_write(wbss_pkg::CSR_RANGE_BASE, 64'd0);
      csr_valid <= 1'b0;
      send_byte(8'hFF, 1'b0);
      for (int i = 1; i < 8; i++) send_byte(8'h00, 1'b0);
      for (int i = 8; i < 15; i++) send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      phase = 0;
      start = sb.scanned;
      while (sb.scanned - start < SCAN_TARGET) begin
         wait_idle();
         pick_scan_setup();
         quiet = (phase == 3 || phase == 4);
         mark = sb.scanned;
         while (sb.scanned - mark < PHASE_BYTES) begin
            roll = $urandom_range(99);
            if (roll < 55) kind = RANGE_PLANTED;
            else if (roll < 70) kind = RANGE_NEAR_MISS;
            else if (roll < 85) kind = RANGE_DENSE;
            else kind = RANGE_NOISE;
            send_range(kind);
         end
         phase++;
      end

      wait_idle();
      sb.check_drained();
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/wbss_pkg.sv
hw/rtl/wbss_match.sv
hw/rtl/wbss_core.sv
hw/rtl/wbss_rsp_queue.sv
hw/rtl/wildcard_byte_signature_scan_top.sv
dv/wildcard_byte_signature_scan_top_tb.sv
